>>> hw/rtl/bpm_pkg.sv
// Shared types and constants for the byte pair merge trainer.
`timescale 1ns / 1ps

package bpm_pkg;

   // Operation codes
   localparam logic [2:0] OP_LOAD  = 3'd0;
   localparam logic [2:0] OP_TRAIN = 3'd1;
   localparam logic [2:0] OP_RULE  = 3'd2;
   localparam logic [2:0] OP_SYM   = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;

   // Status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   // First symbol handed out by a merge rule
   localparam logic [7:0] FIRST_NEW = 8'h80;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [6:0]  symbol_in;
      logic [11:0] index;
   } bpm_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  rule_left;
      logic [7:0]  rule_right;
      logic [7:0]  rule_new;
      logic [7:0]  symbol_out;
      logic [7:0]  rules_learned;
      logic [12:0] current_length;
   } bpm_rsp_type;

   // Commands to the pair counter
   typedef struct packed {
      logic        inc;
      logic        scan;
      logic [15:0] pair;
   } bpm_cnt_cmd_type;

   // Status from the pair counter
   typedef struct packed {
      logic        busy;
      logic        found;
      logic [15:0] best_pair;
   } bpm_cnt_stat_type;

   typedef enum logic [1:0] {
      CNT_CLEAR,
      CNT_IDLE,
      CNT_INC,
      CNT_SCAN
   } bpm_cnt_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      TR_CHECK,
      TR_SYM_RD,
      TR_SYM,
      TR_SCAN_GO,
      TR_SCAN_WAIT,
      TR_RULE,
      TR_REP_RD,
      TR_REP,
      TR_REP_TAIL
   } bpm_state_type;

endpackage

>>> hw/rtl/bpm_pair_counter.sv
// Pair count memory: clearing sweep, increment and read-and-clear maximum scan.
`timescale 1ns / 1ps

module bpm_pair_counter import bpm_pkg::*; #(
   parameter int MAX_SEQ = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  bpm_cnt_cmd_type  cmd,
   output bpm_cnt_stat_type stat
);

   localparam int CNTW = (MAX_SEQ > 2) ? $clog2(MAX_SEQ) : 1;

   logic [CNTW-1:0]   mem [0:65535];
   logic [CNTW-1:0]   rd_q_ff;
   logic [15:0]       rd_addr;
   logic              wr_en;
   logic [15:0]       wr_addr;
   logic [CNTW-1:0]   wr_data;

   bpm_cnt_state_type state_ff, state_in;
   logic [15:0]       addr_ff, addr_in;
   logic              issued_ff, issued_in;
   logic              pend_ff, pend_in;
   logic [15:0]       pend_addr_ff, pend_addr_in;
   logic [CNTW-1:0]   best_ff, best_in;
   logic [15:0]       best_pair_ff, best_pair_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CNT_CLEAR: if (addr_ff == 16'hFFFF) state_in = CNT_IDLE;
         CNT_IDLE: begin
            if (cmd.inc) state_in = CNT_INC;
            else if (cmd.scan) state_in = CNT_SCAN;
         end
         CNT_INC:  state_in = CNT_IDLE;
         CNT_SCAN: if (issued_ff && pend_ff) state_in = CNT_IDLE;
         default:  state_in = CNT_IDLE;
      endcase
   end

   // Memory controls
   always_comb begin
      rd_addr = addr_ff;
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      unique case (state_ff)
         CNT_CLEAR: wr_en = 1'b1;
         CNT_IDLE:  rd_addr = cmd.pair;
         CNT_INC: begin
            wr_en   = 1'b1;
            wr_data = rd_q_ff + CNTW'(1);
         end
         CNT_SCAN: begin
            wr_en   = pend_ff;
            wr_addr = pend_addr_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   // Datapath registers
   always_comb begin
      addr_in      = addr_ff;
      issued_in    = issued_ff;
      pend_in      = 1'b0;
      pend_addr_in = addr_ff;
      best_in      = best_ff;
      best_pair_in = best_pair_ff;
      unique case (state_ff)
         CNT_CLEAR: addr_in = addr_ff + 16'd1;
         CNT_IDLE: begin
            addr_in = cmd.pair;
            if (cmd.scan) begin
               addr_in   = '0;
               issued_in = 1'b0;
               best_in   = '0;
            end
         end
         CNT_INC: addr_in = addr_ff;
         CNT_SCAN: begin
            if (!issued_ff) begin
               pend_in = 1'b1;
               addr_in = addr_ff + 16'd1;
               if (addr_ff == 16'hFFFF) issued_in = 1'b1;
            end
            // strict greater keeps the first pair on a tie
            if (pend_ff && (rd_q_ff > best_ff)) begin
               best_in      = rd_q_ff;
               best_pair_in = pend_addr_ff;
            end
         end
         default: addr_in = addr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= CNT_CLEAR;
         addr_ff   <= '0;
         issued_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         addr_ff   <= addr_in;
         issued_ff <= issued_in;
         pend_ff   <= pend_in;
      end
      pend_addr_ff <= pend_addr_in;
      best_ff      <= best_in;
      best_pair_ff <= best_pair_in;
   end

   assign stat.busy      = (state_ff != CNT_IDLE);
   assign stat.found     = (best_ff != '0);
   assign stat.best_pair = best_pair_ff;

   // Scan visits addresses in order
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CNT_SCAN && pend_ff && $past(pend_ff))
      |-> pend_addr_ff == $past(pend_addr_ff) + 16'd1)
      else $error("pair scan skipped an address");

   // Commands only arrive while idle
   a_cmd_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.inc || cmd.scan) |-> state_ff == CNT_IDLE)
      else $error("pair counter command while busy");

   // Scan ends with every address issued
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CNT_SCAN && state_in == CNT_IDLE) |-> issued_ff)
      else $error("pair scan ended early");

endmodule

>>> hw/rtl/byte_pair_merge_trainer_top.sv
// Top level of the byte pair merge trainer: sequencer, sequence and rule stores.
`timescale 1ns / 1ps

// Usage:
// req_* carries one transaction per command (load, train, read rule, read
// symbol, clear); rsp_* returns one result per command from an output
// register. A new command is taken only once no result waits under rsp_stall.
// csr_* writes merges_requested; write it only while the block is idle.
// Load, clear and unused codes: result registered in the cycle after
// acceptance, one per cycle while rsp_stall is low. Reads: the memory
// output register feeds ST_READ, which loads the result register; no new
// command is taken before that. Train: each merge round walks the sequence
// memory twice (once to count pairs, once to rewrite) and scans the 65536-entry
// pair count memory once, clearing it as it goes; rounds run back to back.
// After reset a clearing pass empties the pair count memory; req_stall
// stays high until it ends. CSR writes are taken at all times.
// When rsp_stall is high a waiting result holds in the result register,
// and req_stall is high for as long as a result waits under rsp_stall.

module byte_pair_merge_trainer_top import bpm_pkg::*; #(
   parameter int MAX_SEQ    = 4096,
   parameter int MAX_MERGES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  bpm_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output bpm_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int AW = (MAX_SEQ > 2) ? $clog2(MAX_SEQ) : 1;
   localparam int LW = $clog2(MAX_SEQ + 1);
   localparam int CW = (LW > 12) ? LW : 12;
   localparam int RW = (MAX_MERGES > 1) ? $clog2(MAX_MERGES) : 1;

   // Memories
   logic [7:0]  seq_mem [0:MAX_SEQ-1];
   logic [23:0] rule_mem [0:MAX_MERGES-1];
   logic [7:0]  seq_q_ff;
   logic [23:0] rule_q_ff;
   logic          seq_we;
   logic [AW-1:0] seq_waddr, seq_raddr;
   logic [7:0]    seq_wdata;
   logic          rule_we;
   logic [RW-1:0] rule_raddr;

   bpm_state_type state_ff, state_in;
   logic [LW-1:0] len_ff, len_in;
   logic [7:0]    rules_ff, rules_in;
   logic [7:0]    merges_ff;
   logic [LW-1:0] i_ff, i_in, w_ff, w_in;
   logic [7:0]    j_ff, j_in;
   logic [7:0]    prev_ff, prev_in, hold_ff, hold_in;
   logic          pend_ff, pend_in;
   logic [7:0]    lft_ff, lft_in, rgt_ff, rgt_in;
   logic [2:0]    op_ff, op_in;
   logic          oor_ff, oor_in;
   logic          rsp_valid_ff, rsp_valid_in;
   bpm_rsp_type   rsp_ff, rsp_in;
   logic          rsp_load;

   bpm_cnt_cmd_type  cnt_cmd;
   bpm_cnt_stat_type cnt_stat;

   logic          req_acc;
   logic          train_stop;
   logic          i_last;
   logic [7:0]    nsym;

   bpm_pair_counter #(.MAX_SEQ(MAX_SEQ)) u_cnt (
      .clock (clock),
      .reset (reset),
      .cmd   (cnt_cmd),
      .stat  (cnt_stat)
   );

   assign req_stall = (state_ff != ST_IDLE) || cnt_stat.busy || (rsp_valid_ff && rsp_stall);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign train_stop = (j_ff >= merges_ff) || (len_ff < LW'(2))
                       || ({1'b0, rules_ff} >= 9'(MAX_MERGES));
   assign i_last     = ((i_ff + LW'(1)) == len_ff);
   assign nsym       = FIRST_NEW + rules_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               priority case (req_data.opcode)
                  OP_TRAIN:       state_in = TR_CHECK;
                  OP_RULE, OP_SYM: state_in = ST_READ;
                  default:        state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ:      state_in = ST_IDLE;
         TR_CHECK:     state_in = train_stop ? ST_IDLE : TR_SYM_RD;
         TR_SYM_RD:    state_in = TR_SYM;
         TR_SYM:       state_in = i_last ? TR_SCAN_GO : TR_SYM_RD;
         TR_SCAN_GO:   if (!cnt_stat.busy) state_in = TR_SCAN_WAIT;
         TR_SCAN_WAIT: if (!cnt_stat.busy) state_in = TR_RULE;
         TR_RULE:      state_in = cnt_stat.found ? TR_REP_RD : ST_IDLE;
         TR_REP_RD:    state_in = TR_REP;
         TR_REP:       state_in = i_last ? TR_REP_TAIL : TR_REP_RD;
         TR_REP_TAIL:  state_in = TR_CHECK;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Memory and counter controls
   always_comb begin
      seq_we     = 1'b0;
      seq_waddr  = AW'(w_ff);
      seq_wdata  = hold_ff;
      seq_raddr  = AW'(i_ff);
      rule_we    = 1'b0;
      rule_raddr = RW'(req_data.index);
      cnt_cmd    = '0;
      cnt_cmd.pair = {prev_ff, seq_q_ff};
      unique case (state_ff)
         ST_IDLE: begin
            seq_raddr = AW'(req_data.index);
            seq_waddr = AW'(len_ff);
            seq_wdata = {1'b0, req_data.symbol_in};
            seq_we    = req_acc && (req_data.opcode == OP_LOAD)
                        && (len_ff < LW'(MAX_SEQ));
         end
         TR_SYM:     cnt_cmd.inc = (i_ff != '0);
         TR_SCAN_GO: cnt_cmd.scan = !cnt_stat.busy;
         TR_RULE:    rule_we = cnt_stat.found;
         TR_REP: begin
            if (pend_ff) begin
               seq_we = 1'b1;
               if (hold_ff == lft_ff && seq_q_ff == rgt_ff) seq_wdata = nsym;
            end
         end
         TR_REP_TAIL: seq_we = pend_ff;
         default: seq_we = 1'b0;
      endcase
   end

   // Datapath registers
   always_comb begin
      len_in   = len_ff;
      rules_in = rules_ff;
      i_in     = i_ff;
      w_in     = w_ff;
      j_in     = j_ff;
      prev_in  = prev_ff;
      hold_in  = hold_ff;
      pend_in  = pend_ff;
      lft_in   = lft_ff;
      rgt_in   = rgt_ff;
      op_in    = op_ff;
      oor_in   = oor_ff;
      rsp_load = 1'b0;
      rsp_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            op_in  = req_data.opcode;
            oor_in = (req_data.opcode == OP_RULE) ? (req_data.index >= 12'(rules_ff))
                                                  : (CW'(req_data.index) >= CW'(len_ff));
            j_in   = '0;
            if (req_acc) begin
               unique case (req_data.opcode)
                  OP_LOAD: begin
                     rsp_load = 1'b1;
                     if (len_ff < LW'(MAX_SEQ)) len_in = len_ff + LW'(1);
                     else rsp_in.status = STAT_FULL;
                  end
                  OP_CLEAR: begin
                     rsp_load = 1'b1;
                     len_in   = '0;
                     rules_in = '0;
                  end
                  OP_TRAIN, OP_RULE, OP_SYM: rsp_load = 1'b0;
                  default: rsp_load = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            rsp_load = 1'b1;
            if (oor_ff) rsp_in.status = STAT_RANGE;
            else if (op_ff == OP_RULE)
               {rsp_in.rule_left, rsp_in.rule_right, rsp_in.rule_new} = rule_q_ff;
            else rsp_in.symbol_out = seq_q_ff;
         end
         TR_CHECK: begin
            i_in     = '0;
            rsp_load = train_stop;
         end
         TR_SYM: begin
            prev_in = seq_q_ff;
            i_in    = i_ff + LW'(1);
         end
         TR_RULE: begin
            rsp_load = !cnt_stat.found;
            lft_in   = cnt_stat.best_pair[15:8];
            rgt_in   = cnt_stat.best_pair[7:0];
            i_in     = '0;
            w_in     = '0;
            pend_in  = 1'b0;
         end
         TR_REP: begin
            i_in    = i_ff + LW'(1);
            hold_in = seq_q_ff;
            pend_in = 1'b1;
            if (pend_ff) begin
               w_in = w_ff + LW'(1);
               if (hold_ff == lft_ff && seq_q_ff == rgt_ff) pend_in = 1'b0;
            end
         end
         TR_REP_TAIL: begin
            len_in   = w_ff + LW'(pend_ff);
            rules_in = rules_ff + 8'd1;
            j_in     = j_ff + 8'd1;
         end
         default: rsp_load = 1'b0;
      endcase
      rsp_in.rules_learned  = rules_in;
      rsp_in.current_length = 13'(len_in);
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   // Sequence and rule memories
   always_ff @(posedge clock) begin
      if (seq_we) seq_mem[seq_waddr] <= seq_wdata;
      seq_q_ff <= seq_mem[seq_raddr];
      if (rule_we) rule_mem[RW'(rules_ff)] <= {cnt_stat.best_pair, nsym};
      rule_q_ff <= rule_mem[rule_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rules_ff     <= '0;
         merges_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rules_ff     <= rules_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         if (csr_valid && csr_ready) merges_ff <= csr_data;
      end
      i_ff    <= i_in;
      w_ff    <= w_in;
      j_ff    <= j_in;
      prev_ff <= prev_in;
      hold_ff <= hold_in;
      lft_ff  <= lft_in;
      rgt_ff  <= rgt_in;
      op_ff   <= op_in;
      oor_ff  <= oor_in;
      if (rsp_load) rsp_ff <= rsp_in;
   end

   // A new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten");

   // Counter is free whenever an increment is issued
   a_inc_free: assert property (@(posedge clock) disable iff (reset)
      cnt_cmd.inc |-> !cnt_stat.busy)
      else $error("pair increment while counter busy");

   // Rewrite pointer never passes the read pointer
   a_write_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == TR_REP) |-> (w_ff <= i_ff))
      else $error("rewrite overtook read");

   // Sequence and rule counts stay in bounds
   a_bounds: assert property (@(posedge clock) disable iff (reset)
      (len_ff <= LW'(MAX_SEQ)) && ({1'b0, rules_ff} <= 9'(MAX_MERGES)))
      else $error("length or rule count out of bounds");

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the byte pair merge trainer top level.
`timescale 1ns / 1ps

module testbench;
   import bpm_pkg::*;

   localparam int SEQ_DEPTH   = 4096;
   localparam int RULE_DEPTH  = 128;
   localparam int RAND_ITEMS  = 1770;
   localparam int ROUND_BUDGET = 11;
   localparam int IDLE_LIMIT  = 1000000;

   typedef struct {
      bit          is_cfg;
      logic [7:0]  cfg_val;
      bpm_req_type rq;
      bit          has_exp;
      bpm_rsp_type ex;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   bpm_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   bpm_rsp_type rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;

   // Predictor state
   logic [7:0]  seq_mem [SEQ_DEPTH];
   int          seq_len;
   logic [7:0]  rule_l [RULE_DEPTH];
   logic [7:0]  rule_r [RULE_DEPTH];
   logic [7:0]  rule_n [RULE_DEPTH];
   int          rule_cnt;
   int          merges_cfg;
   int          rounds_done;

   bpm_rsp_type  rsp_expected [$];
   stim_row_type stim_table [$];
   int           items_sent;
   int           idle_cycles;
   bit           failed;

   byte_pair_merge_trainer_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // No idling in a stretch of the random part
   function automatic bit want_idle();
      if (items_sent >= 700 && items_sent < 1000) return 1'b0;
      return $urandom_range(0, 99) < 9;
   endfunction

   // One merge round on the predicted store; 0 when nothing merged
   function automatic bit merge_once();
      int          tally [int];
      int          best;
      int          best_pair;
      int          w;
      int          i;
      logic [7:0]  lft;
      logic [7:0]  rgt;
      logic [7:0]  nsym;
      if (seq_len < 2 || rule_cnt >= RULE_DEPTH) return 1'b0;
      for (i = 1; i < seq_len; i++) begin
         tally[{seq_mem[i-1], seq_mem[i]}]++;
      end
      best = 0;
      best_pair = 0;
      foreach (tally[k]) begin
         if (tally[k] > best) begin
            best = tally[k];
            best_pair = k;
         end
      end
      if (best == 0) return 1'b0;
      lft  = best_pair[15:8];
      rgt  = best_pair[7:0];
      nsym = FIRST_NEW + rule_cnt[7:0];
      rule_l[rule_cnt] = lft;
      rule_r[rule_cnt] = rgt;
      rule_n[rule_cnt] = nsym;
      rule_cnt++;
      w = 0;
      i = 0;
      while (i < seq_len) begin
         if (i + 1 < seq_len && seq_mem[i] == lft && seq_mem[i+1] == rgt) begin
            seq_mem[w++] = nsym;
            i += 2;
         end else begin
            seq_mem[w++] = seq_mem[i++];
         end
      end
      seq_len = w;
      rounds_done++;
      return 1'b1;
   endfunction

   // Expected result of one command, updating the predicted state
   function automatic bpm_rsp_type merge_predict(bpm_req_type r);
      bpm_rsp_type o;
      int          j;
      o = '0;
      o.status = STAT_OK;
      case (r.opcode)
         OP_LOAD: begin
            if (seq_len >= SEQ_DEPTH) o.status = STAT_FULL;
            else seq_mem[seq_len++] = {1'b0, r.symbol_in};
         end
         OP_TRAIN: begin
            for (j = 0; j < merges_cfg; j++) begin
               if (!merge_once()) break;
               if (seq_len == 1) break;
            end
         end
         OP_RULE: begin
            if (r.index < rule_cnt) begin
               o.rule_left  = rule_l[r.index];
               o.rule_right = rule_r[r.index];
               o.rule_new   = rule_n[r.index];
            end else begin
               o.status = STAT_RANGE;
            end
         end
         OP_SYM: begin
            if (r.index < seq_len) o.symbol_out = seq_mem[r.index];
            else o.status = STAT_RANGE;
         end
         OP_CLEAR: begin
            seq_len  = 0;
            rule_cnt = 0;
         end
         default: ;
      endcase
      o.rules_learned  = rule_cnt[7:0];
      o.current_length = seq_len[12:0];
      return o;
   endfunction

   // Drive one command and record its expected result on acceptance
   task automatic send_cmd(bpm_req_type r, bit has_exp, bpm_rsp_type ex);
      bpm_rsp_type p;
      while (want_idle()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = merge_predict(r);
      rsp_expected.push_back(has_exp ? ex : p);
      items_sent++;
   endtask

   // Wait for the block to drain, then write merges_requested
   task automatic write_merges(logic [7:0] v);
      req_valid <= 1'b0;
      @(posedge clock);
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      merges_cfg = v;
   endtask

   function automatic bpm_req_type mk_req(logic [2:0] op, logic [6:0] sym, logic [11:0] idx);
      bpm_req_type r;
      r.opcode    = op;
      r.symbol_in = sym;
      r.index     = idx;
      return r;
   endfunction

   function automatic bpm_rsp_type mk_rsp(logic [1:0] st, logic [7:0] rules, logic [12:0] len);
      bpm_rsp_type o;
      o = '0;
      o.status         = st;
      o.rules_learned  = rules;
      o.current_length = len;
      return o;
   endfunction

   task automatic add_row(bpm_req_type r);
      stim_row_type s;
      s = '{1'b0, 8'd0, r, 1'b0, '0};
      stim_table.push_back(s);
   endtask

   task automatic add_checked(bpm_req_type r, bpm_rsp_type ex);
      stim_row_type s;
      s = '{1'b0, 8'd0, r, 1'b1, ex};
      stim_table.push_back(s);
   endtask

   task automatic add_cfg(logic [7:0] v);
      stim_row_type s;
      s = '{1'b1, v, '0, 1'b0, '0};
      stim_table.push_back(s);
   endtask

   // Random command; trains only while the round budget lasts
   function automatic bpm_req_type random_cmd();
      int          pick;
      logic [2:0]  op;
      logic [6:0]  sym;
      logic [11:0] idx;
      pick = $urandom_range(0, 99);
      sym  = ($urandom_range(0, 9) < 3) ? 7'($urandom) : 7'($urandom_range(0, 3));
      if ($urandom_range(0, 9) < 3) idx = 12'($urandom);
      else idx = 12'($urandom_range(0, seq_len + 2));
      if (pick < 50) op = OP_LOAD;
      else if (pick < 72) op = OP_SYM;
      else if (pick < 88) begin
         op = OP_RULE;
         if ($urandom_range(0, 1) == 0) idx = 12'($urandom_range(0, rule_cnt + 1));
      end else if (pick < 92) op = (rounds_done + 2 <= ROUND_BUDGET) ? OP_TRAIN : OP_SYM;
      else if (pick < 94) op = OP_CLEAR;
      else op = 3'($urandom_range(5, 7));
      return mk_req(op, sym, idx);
   endfunction

   // Result side: random stall, checking and watchdog
   always @(posedge clock) begin
      bpm_rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_expected.size() == 0) begin
               $error("unexpected result transaction %p", rsp_data);
               failed = 1'b1;
            end else begin
               e = rsp_expected.pop_front();
               if (rsp_data.status !== e.status) begin
                  $error("status: expected %0d actual %0d", e.status, rsp_data.status);
                  failed = 1'b1;
               end
               if (rsp_data.rule_left !== e.rule_left) begin
                  $error("rule_left: expected %0h actual %0h", e.rule_left, rsp_data.rule_left);
                  failed = 1'b1;
               end
               if (rsp_data.rule_right !== e.rule_right) begin
                  $error("rule_right: expected %0h actual %0h", e.rule_right,
                         rsp_data.rule_right);
                  failed = 1'b1;
               end
               if (rsp_data.rule_new !== e.rule_new) begin
                  $error("rule_new: expected %0h actual %0h", e.rule_new, rsp_data.rule_new);
                  failed = 1'b1;
               end
               if (rsp_data.symbol_out !== e.symbol_out) begin
                  $error("symbol_out: expected %0h actual %0h", e.symbol_out,
                         rsp_data.symbol_out);
                  failed = 1'b1;
               end
               if (rsp_data.rules_learned !== e.rules_learned) begin
                  $error("rules_learned: expected %0d actual %0d", e.rules_learned,
                         rsp_data.rules_learned);
                  failed = 1'b1;
               end
               if (rsp_data.current_length !== e.current_length) begin
                  $error("current_length: expected %0d actual %0d", e.current_length,
                         rsp_data.current_length);
                  failed = 1'b1;
               end
            end
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
         rsp_stall <= want_idle();
      end
   end

   // Stimulus
   initial begin
      int n;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      seq_len = 0; rule_cnt = 0; merges_cfg = 0; rounds_done = 0;
      items_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty state, unused codes, train with zero rounds
      add_checked(mk_req(OP_RULE, 7'd0, 12'd0), mk_rsp(STAT_RANGE, 8'd0, 13'd0));
      add_checked(mk_req(OP_SYM, 7'h7f, 12'hfff), mk_rsp(STAT_RANGE, 8'd0, 13'd0));
      add_checked(mk_req(3'd5, 7'h7f, 12'hfff), mk_rsp(STAT_OK, 8'd0, 13'd0));
      add_checked(mk_req(3'd7, 7'd0, 12'd0), mk_rsp(STAT_OK, 8'd0, 13'd0));
      add_checked(mk_req(OP_TRAIN, 7'd0, 12'd0), mk_rsp(STAT_OK, 8'd0, 13'd0));
      // Two rounds with a tied count, tail symbol kept
      add_cfg(8'd2);
      add_checked(mk_req(OP_LOAD, 7'h7f, 12'd0), mk_rsp(STAT_OK, 8'd0, 13'd1));
      add_row(mk_req(OP_LOAD, 7'h00, 12'd0));
      add_row(mk_req(OP_LOAD, 7'h7f, 12'd0));
      add_row(mk_req(OP_LOAD, 7'h00, 12'd0));
      add_row(mk_req(OP_LOAD, 7'h7f, 12'd0));
      add_row(mk_req(OP_TRAIN, 7'd0, 12'd0));
      add_row(mk_req(OP_RULE, 7'd0, 12'd0));
      add_row(mk_req(OP_RULE, 7'd0, 12'd1));
      add_row(mk_req(OP_RULE, 7'd0, 12'd2));
      add_row(mk_req(OP_SYM, 7'd0, 12'd0));
      add_row(mk_req(OP_SYM, 7'd0, 12'd1));
      add_checked(mk_req(OP_CLEAR, 7'd0, 12'd0), mk_rsp(STAT_OK, 8'd0, 13'd0));
      // Many rounds requested; training stops once one symbol is left
      add_cfg(8'd128);
      add_row(mk_req(OP_LOAD, 7'h01, 12'd0));
      add_row(mk_req(OP_LOAD, 7'h01, 12'd0));
      add_row(mk_req(OP_LOAD, 7'h01, 12'd0));
      add_row(mk_req(OP_TRAIN, 7'd0, 12'd0));
      add_row(mk_req(OP_SYM, 7'd0, 12'd0));
      add_row(mk_req(OP_TRAIN, 7'd0, 12'd0));
      add_row(mk_req(OP_RULE, 7'd0, 12'd1));
      add_checked(mk_req(OP_CLEAR, 7'd0, 12'd0), mk_rsp(STAT_OK, 8'd0, 13'd0));

      foreach (stim_table[k]) begin
         if (stim_table[k].is_cfg) write_merges(stim_table[k].cfg_val);
         else send_cmd(stim_table[k].rq, stim_table[k].has_exp, stim_table[k].ex);
      end

      // Random phases at small round counts
      for (n = 0; n < RAND_ITEMS; n++) begin
         if (n % 460 == 0) write_merges(8'($urandom_range(0, 2)));
         send_cmd(random_cmd(), 1'b0, '0);
      end

      // Short sequence, range checks at the top index, then one more round
      write_merges(8'd1);
      send_cmd(mk_req(OP_CLEAR, 7'd0, 12'd0), 1'b0, '0);
      for (n = 0; n < 40; n++) begin
         send_cmd(mk_req(OP_LOAD, 7'($urandom_range(0, 127)), 12'($urandom)), 1'b0, '0);
      end
      send_cmd(mk_req(OP_SYM, 7'd0, 12'hfff), 1'b0, '0);
      send_cmd(mk_req(OP_RULE, 7'd0, 12'hfff), 1'b0, '0);
      send_cmd(mk_req(OP_TRAIN, 7'd0, 12'd0), 1'b0, '0);
      send_cmd(mk_req(OP_RULE, 7'd0, 12'd0), 1'b0, '0);
      send_cmd(mk_req(OP_SYM, 7'd0, 12'd0), 1'b0, '0);
      send_cmd(mk_req(OP_LOAD, 7'h55, 12'd0), 1'b0, '0);

      // Drain
      req_valid <= 1'b0;
      @(posedge clock);
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (!failed && rsp_expected.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/bpm_pkg.sv
hw/rtl/bpm_pair_counter.sv
hw/rtl/byte_pair_merge_trainer_top.sv
bench/testbench.sv
